// ----- src/dsa_pkg.sv -----
// Shared types, constants and the symbol map for the DNA suffix automaton builder.
// Used by dsa_mem, dna_suffix_automaton_build and the testbench; depends on nothing.
package dsa_pkg;

	localparam int MAX_STATES   = 131072;
	localparam int MAX_TEXT_LEN = 65536;
	localparam int IDX_W        = $clog2(MAX_STATES);
	localparam int CNT_W        = IDX_W + 1;
	localparam int LEN_W        = $clog2(MAX_TEXT_LEN) + 1;
	localparam int NSYM         = 4;

	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_G = 8'h47;

	localparam logic [1:0] SYM_A     = 2'd0;
	localparam logic [1:0] SYM_C     = 2'd1;
	localparam logic [1:0] SYM_G     = 2'd2;
	localparam logic [1:0] SYM_OTHER = 2'd3;

	localparam logic CMD_APPEND  = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] symbol;
	} dsa_in_t;

	typedef struct packed {
		logic [16:0] new_state;
		logic [16:0] new_length;
		logic [16:0] suffix_link;
		logic        cloned;
		logic [16:0] clone_state;
		logic [17:0] state_count;
		logic        table_full;
	} dsa_out_t;

	// One automaton state as stored in memory
	typedef struct packed {
		logic [NSYM-1:0]             valid;
		logic [NSYM-1:0][IDX_W-1:0]  trans;
		logic [IDX_W-1:0]            link;
		logic [LEN_W-1:0]            len;
	} dsa_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK,
		ST_WALK,
		ST_WALK_LD,
		ST_Q,
		ST_W_Q,
		ST_W_FRESH,
		ST_RED,
		ST_RED_LD,
		ST_EMIT
	} dsa_state_t;

	function automatic logic [1:0] map_symbol(input logic [7:0] b);
		logic [1:0] s;
		if (b == CHAR_A)      s = SYM_A;
		else if (b == CHAR_C) s = SYM_C;
		else if (b == CHAR_G) s = SYM_G;
		else                  s = SYM_OTHER;
		return s;
	endfunction

endpackage

// ----- src/dsa_mem.sv -----
// State store of the suffix automaton: one synchronous RAM, one write and one read port.
// The root entry reads as empty until written after reset or a clear. Depends on dsa_pkg.
module dsa_mem (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clear,
	input  logic                            wr_en,
	input  logic [dsa_pkg::IDX_W-1:0]       wr_addr,
	input  dsa_pkg::dsa_entry_t             wr_data,
	input  logic                            rd_en,
	input  logic [dsa_pkg::IDX_W-1:0]       rd_addr,
	output dsa_pkg::dsa_entry_t             rd_data
);

	dsa_pkg::dsa_entry_t mem [dsa_pkg::MAX_STATES];
	dsa_pkg::dsa_entry_t raw_q;
	logic                root_clean_q;
	logic                mask_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_clean_q <= 1'b1;
			mask_q       <= 1'b0;
		end else begin
			if (clear) begin
				root_clean_q <= 1'b1;
			end else if (wr_en && wr_addr == '0) begin
				root_clean_q <= 1'b0;
			end
			if (rd_en) begin
				mask_q <= root_clean_q && (rd_addr == '0);
			end
		end
	end

	assign rd_data = mask_q ? '0 : raw_q;

endmodule

// ----- src/dna_suffix_automaton_build.sv -----
// Online suffix automaton builder over a four-letter DNA alphabet.
// A restart clears the RAM and emits its result. An append reads the last state, adds a fresh
// state, walks suffix links adding edges until one on the symbol exists or the root is done,
// and clones that edge's target when its length is not the parent's plus one, then redirects
// edges. Throughput: one item at a time, set by the single-read-port state RAM walked once per hop.
// Reset: root only, last state 0, one state in use; other RAM entries hold nothing valid.
// Depends on dsa_pkg and dsa_mem.
module dna_suffix_automaton_build (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  dsa_pkg::dsa_in_t  item,
	output logic              res_valid,
	input  logic              res_ready,
	output dsa_pkg::dsa_out_t res
);

	dsa_pkg::dsa_state_t state_q, state_nx;

	logic [1:0]                    sym_q;
	logic [dsa_pkg::IDX_W-1:0]     last_q;
	logic [dsa_pkg::CNT_W-1:0]     used_q;
	logic [dsa_pkg::IDX_W-1:0]     fresh_q;
	logic [dsa_pkg::LEN_W-1:0]     flen_q;
	logic [dsa_pkg::IDX_W-1:0]     p_q;
	dsa_pkg::dsa_entry_t           pent_q;
	logic [dsa_pkg::IDX_W-1:0]     q_q;
	dsa_pkg::dsa_entry_t           qent_q;
	logic [dsa_pkg::IDX_W-1:0]     twin_q;
	dsa_pkg::dsa_out_t             res_q;
	dsa_pkg::dsa_out_t             out_q;
	logic                          out_valid_q;

	logic                          wr_en, rd_en, clear;
	logic [dsa_pkg::IDX_W-1:0]     wr_addr, rd_addr;
	dsa_pkg::dsa_entry_t           wr_data, rd_data;

	logic                          refuse;
	logic                          p_has;
	logic                          p_hits_q;
	logic                          len_match;
	logic                          out_load;

	dsa_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (clear),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Refuse an append when the text is at full length or fewer than two states remain
	assign refuse = (rd_data.len >= dsa_pkg::LEN_W'(dsa_pkg::MAX_TEXT_LEN))
		|| (used_q > dsa_pkg::CNT_W'(dsa_pkg::MAX_STATES - 2));
	assign p_has     = pent_q.valid[sym_q];
	assign p_hits_q  = p_has && (pent_q.trans[sym_q] == q_q);
	assign len_match = (pent_q.len + 1'b1) == rd_data.len;
	assign out_load  = (state_q == dsa_pkg::ST_EMIT) && (!out_valid_q || res_ready);

	assign item_ready = (state_q == dsa_pkg::ST_IDLE);
	assign res_valid  = out_valid_q;
	assign res        = out_q;

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			dsa_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_nx = (item.cmd == dsa_pkg::CMD_RESTART) ? dsa_pkg::ST_EMIT
						: dsa_pkg::ST_CHK;
				end
			end
			dsa_pkg::ST_CHK: begin
				state_nx = refuse ? dsa_pkg::ST_EMIT : dsa_pkg::ST_WALK;
			end
			dsa_pkg::ST_WALK: begin
				if (p_has)              state_nx = dsa_pkg::ST_Q;
				else if (p_q == '0)     state_nx = dsa_pkg::ST_EMIT;
				else                    state_nx = dsa_pkg::ST_WALK_LD;
			end
			dsa_pkg::ST_WALK_LD: state_nx = dsa_pkg::ST_WALK;
			dsa_pkg::ST_Q: begin
				state_nx = len_match ? dsa_pkg::ST_EMIT : dsa_pkg::ST_W_Q;
			end
			dsa_pkg::ST_W_Q:     state_nx = dsa_pkg::ST_W_FRESH;
			dsa_pkg::ST_W_FRESH: state_nx = dsa_pkg::ST_RED;
			dsa_pkg::ST_RED: begin
				if (p_hits_q && p_q != '0) state_nx = dsa_pkg::ST_RED_LD;
				else                       state_nx = dsa_pkg::ST_EMIT;
			end
			dsa_pkg::ST_RED_LD: state_nx = dsa_pkg::ST_RED;
			dsa_pkg::ST_EMIT: begin
				if (out_load) state_nx = dsa_pkg::ST_IDLE;
			end
			default: state_nx = dsa_pkg::ST_IDLE;
		endcase
	end

	// Memory port controls
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = '0;
		clear   = 1'b0;
		unique case (state_q)
			dsa_pkg::ST_IDLE: begin
				if (item_valid) begin
					if (item.cmd == dsa_pkg::CMD_RESTART) begin
						clear = 1'b1;
					end else begin
						rd_en   = 1'b1;
						rd_addr = last_q;
					end
				end
			end
			dsa_pkg::ST_CHK: begin
				// allocate the fresh state: no edges, link to root for now
				if (!refuse) begin
					wr_en       = 1'b1;
					wr_addr     = used_q[dsa_pkg::IDX_W-1:0];
					wr_data.len = rd_data.len + 1'b1;
				end
			end
			dsa_pkg::ST_WALK: begin
				if (p_has) begin
					rd_en   = 1'b1;
					rd_addr = pent_q.trans[sym_q];
				end else begin
					wr_en                 = 1'b1;
					wr_addr               = p_q;
					wr_data               = pent_q;
					wr_data.valid[sym_q]  = 1'b1;
					wr_data.trans[sym_q]  = fresh_q;
					if (p_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = pent_q.link;
					end
				end
			end
			dsa_pkg::ST_Q: begin
				wr_en = 1'b1;
				if (len_match) begin
					wr_addr      = fresh_q;
					wr_data.len  = flen_q;
					wr_data.link = q_q;
				end else begin
					// clone of q with the shorter length
					wr_addr     = used_q[dsa_pkg::IDX_W-1:0];
					wr_data     = rd_data;
					wr_data.len = pent_q.len + 1'b1;
				end
			end
			dsa_pkg::ST_W_Q: begin
				wr_en        = 1'b1;
				wr_addr      = q_q;
				wr_data      = qent_q;
				wr_data.link = twin_q;
			end
			dsa_pkg::ST_W_FRESH: begin
				wr_en        = 1'b1;
				wr_addr      = fresh_q;
				wr_data.len  = flen_q;
				wr_data.link = twin_q;
			end
			dsa_pkg::ST_RED: begin
				if (p_hits_q) begin
					wr_en                = 1'b1;
					wr_addr              = p_q;
					wr_data              = pent_q;
					wr_data.trans[sym_q] = twin_q;
					if (p_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = pent_q.link;
					end
				end
			end
			dsa_pkg::ST_WALK_LD, dsa_pkg::ST_RED_LD, dsa_pkg::ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dsa_pkg::ST_IDLE;
			last_q      <= '0;
			used_q      <= dsa_pkg::CNT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				dsa_pkg::ST_IDLE: begin
					if (item_valid && item.cmd == dsa_pkg::CMD_RESTART) begin
						last_q <= '0;
						used_q <= dsa_pkg::CNT_W'(1);
					end
				end
				dsa_pkg::ST_CHK: begin
					if (!refuse) used_q <= used_q + 1'b1;
				end
				dsa_pkg::ST_WALK: begin
					if (!p_has && p_q == '0) last_q <= fresh_q;
				end
				dsa_pkg::ST_Q: begin
					if (len_match) last_q <= fresh_q;
					else           used_q <= used_q + 1'b1;
				end
				dsa_pkg::ST_RED: begin
					if (!(p_hits_q && p_q != '0)) last_q <= fresh_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath: walk registers and the pending result
	always_ff @(posedge clk) begin
		if (out_load) out_q <= res_q;
		unique case (state_q)
			dsa_pkg::ST_IDLE: begin
				sym_q <= dsa_pkg::map_symbol(item.symbol);
				res_q <= '{state_count: dsa_pkg::CNT_W'(1), default: '0};
			end
			dsa_pkg::ST_CHK: begin
				fresh_q <= used_q[dsa_pkg::IDX_W-1:0];
				flen_q  <= rd_data.len + 1'b1;
				pent_q  <= rd_data;
				p_q     <= last_q;
				// hold the refusal result; the append path overwrites it
				res_q.new_state   <= last_q;
				res_q.new_length  <= rd_data.len;
				res_q.suffix_link <= rd_data.link;
				res_q.cloned      <= 1'b0;
				res_q.clone_state <= '0;
				res_q.state_count <= used_q;
				res_q.table_full  <= 1'b1;
			end
			dsa_pkg::ST_WALK: begin
				if (p_has) begin
					q_q <= pent_q.trans[sym_q];
				end else begin
					p_q <= pent_q.link;
					if (p_q == '0) begin
						res_q.new_state   <= fresh_q;
						res_q.new_length  <= flen_q;
						res_q.suffix_link <= '0;
						res_q.state_count <= used_q;
						res_q.table_full  <= 1'b0;
					end
				end
			end
			dsa_pkg::ST_WALK_LD, dsa_pkg::ST_RED_LD: begin
				pent_q <= rd_data;
			end
			dsa_pkg::ST_Q: begin
				qent_q <= rd_data;
				twin_q <= used_q[dsa_pkg::IDX_W-1:0];
				res_q.new_state   <= fresh_q;
				res_q.new_length  <= flen_q;
				res_q.table_full  <= 1'b0;
				if (len_match) begin
					res_q.suffix_link <= q_q;
					res_q.state_count <= used_q;
				end else begin
					res_q.suffix_link <= used_q[dsa_pkg::IDX_W-1:0];
					res_q.cloned      <= 1'b1;
					res_q.clone_state <= used_q[dsa_pkg::IDX_W-1:0];
					res_q.state_count <= used_q + 1'b1;
				end
			end
			dsa_pkg::ST_RED: begin
				p_q <= pent_q.link;
			end
			dsa_pkg::ST_W_Q, dsa_pkg::ST_W_FRESH, dsa_pkg::ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- tb/sv/dsa_checker.sv -----
// Checker for dna_suffix_automaton_build: watches both channels, keeps a
// private copy of the automaton and compares each result with its prediction.
// Depends on dsa_pkg.
module dsa_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  dsa_pkg::dsa_in_t  item,
	input  logic              res_valid,
	input  logic              res_ready,
	input  dsa_pkg::dsa_out_t res,
	output int                errors,
	output int                pending
);

	localparam int NODES = 4096;

	logic [3:0]       node_has[NODES];
	logic [16:0]      node_to[NODES][4];
	logic [16:0]      node_link[NODES];
	logic [16:0]      node_len[NODES];
	logic [16:0]      tail;
	logic [17:0]      used;
	dsa_pkg::dsa_out_t want_q[$];

	function automatic logic [1:0] code_of(input logic [7:0] b);
		logic [1:0] c;
		case (b)
			dsa_pkg::CHAR_A: c = dsa_pkg::SYM_A;
			dsa_pkg::CHAR_C: c = dsa_pkg::SYM_C;
			dsa_pkg::CHAR_G: c = dsa_pkg::SYM_G;
			default: c = dsa_pkg::SYM_OTHER;
		endcase
		return c;
	endfunction

	function automatic dsa_pkg::dsa_out_t describe(input logic [16:0] s, input logic cl,
		input logic [16:0] cs, input logic full);
		dsa_pkg::dsa_out_t o;
		o.new_state   = s;
		o.new_length  = node_len[s];
		o.suffix_link = node_link[s];
		o.cloned      = cl;
		o.clone_state = cs;
		o.state_count = used;
		o.table_full  = full;
		return o;
	endfunction

	task automatic clear_root();
		node_has[0] = '0;
		node_link[0] = '0;
		node_len[0] = '0;
		tail = '0;
		used = 18'd1;
	endtask

	// Extend the automaton by one item and queue what it yields.
	task automatic extend(input dsa_pkg::dsa_in_t it);
		logic [1:0]  c;
		logic [16:0] fresh, p, q, twin;
		logic        found, cl;
		found = 1'b0; cl = 1'b0; twin = '0;
		if (it.cmd == dsa_pkg::CMD_RESTART) begin
			clear_root();
			want_q.push_back(describe('0, 1'b0, '0, 1'b0));
			return;
		end
		c = code_of(it.symbol);
		if (node_len[tail] >= dsa_pkg::MAX_TEXT_LEN || used > dsa_pkg::MAX_STATES - 2) begin
			want_q.push_back(describe(tail, 1'b0, '0, 1'b1));
			return;
		end
		fresh = used[16:0];
		used++;
		node_len[fresh] = 17'(node_len[tail] + 1);
		node_has[fresh] = '0;
		node_link[fresh] = '0;
		p = tail;
		forever begin
			if (node_has[p][c]) begin
				found = 1'b1;
				break;
			end
			node_has[p][c] = 1'b1;
			node_to[p][c] = fresh;
			if (p == 0) break;
			p = node_link[p];
		end
		if (found) begin
			q = node_to[p][c];
			if (node_len[p] + 1 == node_len[q]) begin
				node_link[fresh] = q;
			end else begin
				twin = used[16:0];
				used++;
				node_link[twin] = node_link[q];
				node_len[twin] = 17'(node_len[p] + 1);
				node_to[twin] = node_to[q];
				node_has[twin] = node_has[q];
				forever begin
					if (!node_has[p][c] || node_to[p][c] != q) break;
					node_to[p][c] = twin;
					if (p == 0) break;
					p = node_link[p];
				end
				node_link[fresh] = twin;
				node_link[q] = twin;
				cl = 1'b1;
			end
		end
		tail = fresh;
		want_q.push_back(describe(fresh, cl, twin, 1'b0));
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("checker: %s got %0d expected %0d at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	initial begin
		errors = 0;
		clear_root();
	end

	assign pending = want_q.size();

	always @(posedge clk) begin
		dsa_pkg::dsa_out_t w;
		if (arst_n && item_valid && item_ready)
			extend(item);
		if (arst_n && res_valid && res_ready) begin
			if (want_q.size() == 0) begin
				report("unexpected result", res.new_state, 0);
			end else begin
				w = want_q.pop_front();
				if (res.new_state !== w.new_state)     report("new_state", res.new_state, w.new_state);
				if (res.new_length !== w.new_length)   report("new_length", res.new_length, w.new_length);
				if (res.suffix_link !== w.suffix_link) report("suffix_link", res.suffix_link, w.suffix_link);
				if (res.cloned !== w.cloned)           report("cloned", res.cloned, w.cloned);
				if (res.clone_state !== w.clone_state) report("clone_state", res.clone_state, w.clone_state);
				if (res.state_count !== w.state_count) report("state_count", res.state_count, w.state_count);
				if (res.table_full !== w.table_full)   report("table_full", res.table_full, w.table_full);
			end
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the testbench for dna_suffix_automaton_build: clock, reset, stimulus
// and verdict. Depends on dsa_pkg, the block and dsa_checker.
module tb;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	dsa_pkg::dsa_in_t  item;
	logic              res_valid;
	logic              res_ready;
	dsa_pkg::dsa_out_t res;
	int                errors;
	int                pending;

	// Idle odds in percent for each side; changed between phases.
	int       send_idle;
	int       recv_idle;
	int       hold_off;        // cycles the receiver must still refuse
	int       since_restart;   // appends since the last restart

	dna_suffix_automaton_build dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	dsa_checker chk (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Ready side: a long hold-off wins, otherwise drop ready at random.
	initial begin
		res_ready = 0;
		hold_off = 0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				hold_off--;
				res_ready <= 0;
			end else begin
				res_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Offer one transfer and hold it until accepted; idle beforehand at random.
	task automatic offer(input logic c, input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 0;
			@(posedge clk);
		end
		item_valid <= 1;
		item.cmd <= c;
		item.symbol <= b;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		if (c == dsa_pkg::CMD_RESTART) since_restart = 0;
		else since_restart++;
	endtask

	// Mostly real bases, sometimes other bytes; small alphabets give many clones.
	function automatic logic [7:0] pick_base();
		logic [7:0] b;
		case ($urandom_range(9))
			0, 1, 2: b = dsa_pkg::CHAR_A;
			3, 4:    b = dsa_pkg::CHAR_C;
			5, 6:    b = dsa_pkg::CHAR_G;
			7:       b = 8'h54;
			default: b = 8'($urandom_range(255));
		endcase
		return b;
	endfunction

	initial begin
		arst_n = 0;
		item_valid = 0;
		item = '0;
		send_idle = 0;
		recv_idle = 0;
		since_restart = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: restart, every base, byte extremes, repeats that force clones.
		offer(dsa_pkg::CMD_RESTART, 8'hFF);
		offer(dsa_pkg::CMD_APPEND, dsa_pkg::CHAR_A);
		offer(dsa_pkg::CMD_APPEND, dsa_pkg::CHAR_A);
		offer(dsa_pkg::CMD_APPEND, dsa_pkg::CHAR_C);
		offer(dsa_pkg::CMD_APPEND, dsa_pkg::CHAR_A);
		offer(dsa_pkg::CMD_APPEND, dsa_pkg::CHAR_A);
		offer(dsa_pkg::CMD_APPEND, dsa_pkg::CHAR_C);
		offer(dsa_pkg::CMD_APPEND, dsa_pkg::CHAR_G);
		offer(dsa_pkg::CMD_APPEND, 8'h00);
		offer(dsa_pkg::CMD_APPEND, 8'hFF);
		offer(dsa_pkg::CMD_APPEND, 8'h54);
		offer(dsa_pkg::CMD_APPEND, 8'hAA);
		offer(dsa_pkg::CMD_APPEND, 8'h55);
		offer(dsa_pkg::CMD_APPEND, dsa_pkg::CHAR_G);
		offer(dsa_pkg::CMD_APPEND, dsa_pkg::CHAR_A);
		offer(dsa_pkg::CMD_RESTART, 8'h00);
		offer(dsa_pkg::CMD_APPEND, dsa_pkg::CHAR_C);
		offer(dsa_pkg::CMD_APPEND, dsa_pkg::CHAR_C);
		offer(dsa_pkg::CMD_APPEND, dsa_pkg::CHAR_C);
		offer(dsa_pkg::CMD_RESTART, dsa_pkg::CHAR_A);
		offer(dsa_pkg::CMD_RESTART, dsa_pkg::CHAR_G);

		// Long receiver hold-off while the sender keeps offering.
		hold_off = 200;
		for (int i = 0; i < 20; i++) offer(dsa_pkg::CMD_APPEND, pick_base());

		// Three idle phases; restart often so the checker's table stays small.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 18 : (ph == 1) ? 70 : 0;
			recv_idle = (ph == 0) ? 70 : (ph == 1) ? 18 : 0;
			for (int i = 0; i < 570; i++) begin
				if (since_restart > 1500 || $urandom_range(199) == 0)
					offer(dsa_pkg::CMD_RESTART, 8'($urandom_range(255)));
				else
					offer(dsa_pkg::CMD_APPEND, pick_base());
			end
		end
		item_valid <= 0;

		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("tb: done, errors");
		$finish;
	end

endmodule

// ----- dna_suffix_automaton_build.f -----
src/dsa_pkg.sv
src/dsa_mem.sv
src/dna_suffix_automaton_build.sv
tb/sv/dsa_checker.sv
tb/sv/tb.sv
